// File: rtl/image_tile_average_defines.svh
// Assertion macros shared by the checker of the tile averaging block.
// Needs a clock named clock and an active high reset named reset in scope.
`ifndef IMAGE_TILE_AVERAGE_DEFINES_SVH
`define IMAGE_TILE_AVERAGE_DEFINES_SVH

// Same-cycle implication.
`define ITA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ITA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ita_pkg.sv
// Types and constants of the tile averaging block.
// No dependencies; every file but the assertion macro header refers to it by scoped names.
package ita_pkg;

   localparam int DIM_W      = 13;           // frame and tile dimensions
   localparam int CNT_W      = 9;            // tile counts per axis
   localparam int SLD_W      = 7;
   localparam int NUM_W      = 16;           // geometry divider operands
   localparam int AREA_W     = 2 * DIM_W;
   localparam int CH_W       = 8;
   localparam int SUM_W      = AREA_W + CH_W;
   localparam int MEAN_STEPS = 8;            // quotient is below 2**CH_W
   localparam int TCOL_W     = 8;
   localparam int TROW_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [SLD_W-1:0] SLIDER_FULL = 7'd127;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIDER_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIDER_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TILES_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TILES_Y  = 3'd5;

   localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [SLD_W-1:0] RST_SLIDER       = 7'd0;
   localparam logic [CNT_W-1:0] RST_MAX_TILES_X  = 9'd64;
   localparam logic [CNT_W-1:0] RST_MAX_TILES_Y  = 9'd48;

   typedef struct packed {
      logic [CH_W-1:0] chan_a;
      logic [CH_W-1:0] chan_b;
      logic [CH_W-1:0] chan_c;
   } pixel_type;

   typedef struct packed {
      logic [CH_W-1:0]   avg_a;
      logic [CH_W-1:0]   avg_b;
      logic [CH_W-1:0]   avg_c;
      logic [TCOL_W-1:0] tile_col;
      logic [TROW_W-1:0] tile_row;
      logic              frame_done;
   } tile_type;

   // Frame geometry derived from the registers.
   typedef struct packed {
      logic [DIM_W-1:0]  fw;
      logic [DIM_W-1:0]  fh;
      logic [DIM_W-1:0]  tw;
      logic [DIM_W-1:0]  th;
      logic [DIM_W-1:0]  ncols;
      logic [DIM_W-1:0]  nrows;
      logic [AREA_W-1:0] area;
   } geom_type;

   typedef logic [2:0][SUM_W-1:0] sum3_type;
   typedef logic [2:0][CH_W-1:0]  mean3_type;

endpackage

// File: rtl/ita_req_if.sv
// Valid/ready channel carrying one pixel per beat.
// Depends on ita_pkg.
interface ita_req_if;
   logic                valid;
   logic                ready;
   ita_pkg::pixel_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ita_rsp_if.sv
// Valid/ready channel carrying one tile average per beat.
// Depends on ita_pkg.
interface ita_rsp_if;
   logic               valid;
   logic               ready;
   ita_pkg::tile_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/image_tile_average.sv
// Tile averaging top level. A pixel inside a kept tile is accepted, then goes through a sum
// RAM read-modify-write; a pixel outside every kept tile needs only the accept. A pixel that
// closes a tile also runs the mean divider and one output load, which waits while the result
// port stalls, before the next pixel is taken. Reset (synchronous) and each register write run
// the geometry sequencer with req ready low: two reciprocal counts, four divisions, one multiply.
// The sum RAM needs no clearing: tile sums restart at top-left.
module image_tile_average #(
   parameter int MAX_TILE_COLS = 256,
   parameter int MAX_DIM       = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ita_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ita_pkg::CSR_DATA_W-1:0] csr_wdata,
   ita_req_if.sink                        req_bus,
   ita_rsp_if.source                      rsp_bus
);

   localparam int CW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
   localparam int DW = ita_pkg::DIM_W;
   localparam logic [DW-1:0] MaxCols = DW'(MAX_TILE_COLS);
   localparam logic [DW:0]   One = (DW+1)'(1);

   typedef enum logic [1:0] {S_IDLE, S_UPD, S_MEAN, S_OUT} state_type;

   state_type state_ff, state_in;
   logic [DW-1:0] x_ff, x_in, y_ff, y_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [DW-1:0] col_ff, col_in, row_ff, row_in;
   logic [DW-1:0] icol_ff, icol_in, irow_ff, irow_in;
   logic first_ff, first_in, emit_ff, emit_in, fdone_ff, fdone_in;
   ita_pkg::pixel_type pix_ff, pix_in;
   ita_pkg::geom_type  act_ff, act_in, cur, pend;
   ita_pkg::sum3_type  rd_ff, new_sums;
   ita_pkg::tile_type  rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   ita_pkg::sum3_type  sum_mem [MAX_TILE_COLS];
   ita_pkg::mean3_type mean;
   logic geom_busy, mean_done, mean_start, acc;
   logic [DW-1:0] kept;
   logic in_range, last, fdone, x_end, y_end, dx_end, dy_end;

   ita_geom #(.MAX_DIM(MAX_DIM)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (geom_busy),
      .geom      (pend)
   );

   ita_mean u_mean (
      .clock (clock),
      .reset (reset),
      .start (mean_start),
      .sums  (new_sums),
      .area  (act_ff.area),
      .done  (mean_done),
      .mean  (mean)
   );

   assign req_bus.ready = (state_ff == S_IDLE) && !geom_busy;
   assign acc           = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;
   assign mean_start    = (state_ff == S_UPD) && emit_ff;

   // geometry is taken from the registers at the first pixel of a frame
   assign cur  = (x_ff == '0 && y_ff == '0) ? pend : act_ff;
   assign kept = (cur.ncols > MaxCols) ? MaxCols : cur.ncols;

   always_comb begin
      in_range = (cur.tw != '0) && (cur.th != '0) && (col_ff < kept) && (row_ff < cur.nrows);
      dx_end   = ({1'b0, dx_ff} + One) == {1'b0, cur.tw};
      dy_end   = ({1'b0, dy_ff} + One) == {1'b0, cur.th};
      last     = dx_end && dy_end;
      fdone    = (({1'b0, col_ff} + One) == {1'b0, kept}) &&
                 (({1'b0, row_ff} + One) == {1'b0, cur.nrows});
      x_end    = ({1'b0, x_ff} + One) >= {1'b0, cur.fw};
      y_end    = ({1'b0, y_ff} + One) >= {1'b0, cur.fh};
      for (int i = 0; i < 3; i++) begin
         new_sums[i] = first_ff ? '0 : rd_ff[i];
      end
      new_sums[0] = new_sums[0] + ita_pkg::SUM_W'(pix_ff.chan_a);
      new_sums[1] = new_sums[1] + ita_pkg::SUM_W'(pix_ff.chan_b);
      new_sums[2] = new_sums[2] + ita_pkg::SUM_W'(pix_ff.chan_c);
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      icol_in      = icol_ff;
      irow_in      = irow_ff;
      first_in     = first_ff;
      emit_in      = emit_ff;
      fdone_in     = fdone_ff;
      pix_in       = pix_ff;
      act_in       = act_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               act_in   = cur;
               pix_in   = req_bus.data;
               icol_in  = col_ff;
               irow_in  = row_ff;
               first_in = (dx_ff == '0) && (dy_ff == '0);
               emit_in  = last;
               fdone_in = fdone;
               state_in = in_range ? S_UPD : S_IDLE;
               if (x_end) begin
                  x_in   = '0;
                  dx_in  = '0;
                  col_in = '0;
                  if (y_end) begin
                     y_in   = '0;
                     dy_in  = '0;
                     row_in = '0;
                  end else begin
                     y_in = y_ff + 1'b1;
                     if (dy_end) begin
                        dy_in  = '0;
                        row_in = row_ff + 1'b1;
                     end else begin
                        dy_in = dy_ff + 1'b1;
                     end
                  end
               end else begin
                  x_in = x_ff + 1'b1;
                  if (dx_end) begin
                     dx_in  = '0;
                     col_in = col_ff + 1'b1;
                  end else begin
                     dx_in = dx_ff + 1'b1;
                  end
               end
            end
         end
         S_UPD: state_in = emit_ff ? S_MEAN : S_IDLE;
         S_MEAN: if (mean_done) state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_in.avg_a      = mean[0];
               rsp_in.avg_b      = mean[1];
               rsp_in.avg_c      = mean[2];
               rsp_in.tile_col   = icol_ff[ita_pkg::TCOL_W-1:0];
               rsp_in.tile_row   = irow_ff[ita_pkg::TROW_W-1:0];
               rsp_in.frame_done = fdone_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      icol_ff  <= icol_in;
      irow_ff  <= irow_in;
      first_ff <= first_in;
      emit_ff  <= emit_in;
      fdone_ff <= fdone_in;
      pix_ff   <= pix_in;
      act_ff   <= act_in;
      rsp_ff   <= rsp_in;
   end

   // per-column sum RAM, read on accept, written back in the next cycle
   always_ff @(posedge clock) begin
      if (acc) rd_ff <= sum_mem[col_ff[CW-1:0]];
      if (state_ff == S_UPD) sum_mem[icol_ff[CW-1:0]] <= new_sums;
   end

endmodule

// File: rtl/ita_geom.sv
// Register file and geometry sequencer: tile counts by reciprocal multiply, then tile sides
// and tiles per frame through one shared restoring divider, tile area by one multiply. Uses ita_pkg.
module ita_geom #(
   parameter int MAX_DIM = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [ita_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ita_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           busy,
   output ita_pkg::geom_type              geom
);

   localparam int DimMax = (1 << ita_pkg::DIM_W) - 1;
   localparam logic [ita_pkg::DIM_W-1:0] ClampDim =
      ita_pkg::DIM_W'((MAX_DIM > DimMax) ? DimMax : MAX_DIM);
   localparam int NW = ita_pkg::NUM_W;
   localparam int RW = NW + 17;
   localparam int RecipShift = 23;
   // ceil(2**23 / 127): exact floor division for numerators up to 127 * 511
   localparam logic [RW-1:0] Recip127 = RW'(66053);

   typedef enum logic [2:0] {G_IDLE, G_LOAD, G_DIV, G_RECIP, G_STORE, G_MUL} gstate_type;
   typedef enum logic [2:0] {OP_CX, OP_CY, OP_TW, OP_TH, OP_NC, OP_NR} op_type;

   gstate_type state_ff, state_in;
   op_type     op_ff, op_in;
   logic [ita_pkg::DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [ita_pkg::SLD_W-1:0] slx_ff, slx_in, sly_ff, sly_in;
   logic [ita_pkg::CNT_W-1:0] mtx_ff, mtx_in, mty_ff, mty_in;
   logic [ita_pkg::CNT_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [NW-1:0] n_ff, n_in, d_ff, d_in, q_ff, q_in;
   logic [NW:0]   rem_ff, rem_in, rem_t;
   logic [RW-1:0] prod;
   logic [$clog2(NW)-1:0] cnt_ff, cnt_in;
   ita_pkg::geom_type geom_ff, geom_in;
   logic [ita_pkg::CNT_W-1:0] q_cnt;

   function automatic logic [ita_pkg::DIM_W-1:0] clamp_dim(input logic [ita_pkg::DIM_W-1:0] d);
      logic [ita_pkg::DIM_W-1:0] r;
      r = d;
      if (d == '0) r = ita_pkg::DIM_W'(1);
      else if (d > ClampDim) r = ClampDim;
      return r;
   endfunction

   assign busy = (state_ff != G_IDLE);
   assign geom = geom_ff;
   // count floors at one
   assign q_cnt = (q_ff == '0) ? ita_pkg::CNT_W'(1) : q_ff[ita_pkg::CNT_W-1:0];

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      width_in  = width_ff;
      height_in = height_ff;
      slx_in    = slx_ff;
      sly_in    = sly_ff;
      mtx_in    = mtx_ff;
      mty_in    = mty_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      geom_in   = geom_ff;
      rem_t     = {rem_ff[NW-1:0], n_ff[NW-1]};
      prod      = RW'(n_ff) * Recip127;
      case (state_ff)
         G_LOAD: begin
            case (op_ff)
               OP_CX: begin
                  n_in = NW'(ita_pkg::SLIDER_FULL - slx_ff) * NW'(mtx_ff);
                  geom_in.fw = clamp_dim(width_ff);
                  geom_in.fh = clamp_dim(height_ff);
               end
               OP_CY: begin
                  n_in = NW'(ita_pkg::SLIDER_FULL - sly_ff) * NW'(mty_ff);
               end
               OP_TW: begin
                  n_in = NW'(geom_ff.fw);
                  d_in = NW'(cx_ff);
               end
               OP_TH: begin
                  n_in = NW'(geom_ff.fh);
                  d_in = NW'(cy_ff);
               end
               OP_NC: begin
                  n_in = NW'(geom_ff.fw);
                  d_in = NW'(geom_ff.tw);
               end
               OP_NR: begin
                  n_in = NW'(geom_ff.fh);
                  d_in = NW'(geom_ff.th);
               end
               default: begin
                  n_in = '0;
                  d_in = '0;
               end
            endcase
            rem_in   = '0;
            q_in     = '0;
            cnt_in   = '0;
            // division by the slider span goes through the reciprocal
            state_in = ((op_ff == OP_CX) || (op_ff == OP_CY)) ? G_RECIP : G_DIV;
         end
         G_RECIP: begin
            q_in     = NW'(prod >> RecipShift);
            state_in = G_STORE;
         end
         G_DIV: begin
            n_in = {n_ff[NW-2:0], 1'b0};
            if (rem_t >= {1'b0, d_ff}) begin
               rem_in = rem_t - {1'b0, d_ff};
               q_in   = {q_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_t;
               q_in   = {q_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '1) state_in = G_STORE;
         end
         G_STORE: begin
            state_in = G_LOAD;
            case (op_ff)
               OP_CX: begin
                  cx_in = q_cnt;
                  op_in = OP_CY;
               end
               OP_CY: begin
                  cy_in = q_cnt;
                  op_in = OP_TW;
               end
               OP_TW: begin
                  geom_in.tw = q_ff[ita_pkg::DIM_W-1:0];
                  op_in = OP_TH;
               end
               OP_TH: begin
                  geom_in.th = q_ff[ita_pkg::DIM_W-1:0];
                  op_in = OP_NC;
               end
               OP_NC: begin
                  geom_in.ncols = q_ff[ita_pkg::DIM_W-1:0];
                  op_in = OP_NR;
               end
               OP_NR: begin
                  geom_in.nrows = q_ff[ita_pkg::DIM_W-1:0];
                  state_in = G_MUL;
               end
               default: state_in = G_IDLE;
            endcase
         end
         G_MUL: begin
            geom_in.area = ita_pkg::AREA_W'(geom_ff.tw) * ita_pkg::AREA_W'(geom_ff.th);
            state_in = G_IDLE;
         end
         G_IDLE: ;
         default: state_in = G_IDLE;
      endcase
      // any register write restarts the sequence
      if (csr_we) begin
         case (csr_index)
            ita_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            ita_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            ita_pkg::CSR_SLIDER_X:     slx_in    = csr_wdata[ita_pkg::SLD_W-1:0];
            ita_pkg::CSR_SLIDER_Y:     sly_in    = csr_wdata[ita_pkg::SLD_W-1:0];
            ita_pkg::CSR_MAX_TILES_X:  mtx_in    = csr_wdata[ita_pkg::CNT_W-1:0];
            ita_pkg::CSR_MAX_TILES_Y:  mty_in    = csr_wdata[ita_pkg::CNT_W-1:0];
            default: ;
         endcase
         state_in = G_LOAD;
         op_in    = OP_CX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= G_LOAD;
         op_ff     <= OP_CX;
         width_ff  <= ita_pkg::RST_IMAGE_WIDTH;
         height_ff <= ita_pkg::RST_IMAGE_HEIGHT;
         slx_ff    <= ita_pkg::RST_SLIDER;
         sly_ff    <= ita_pkg::RST_SLIDER;
         mtx_ff    <= ita_pkg::RST_MAX_TILES_X;
         mty_ff    <= ita_pkg::RST_MAX_TILES_Y;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         slx_ff    <= slx_in;
         sly_ff    <= sly_in;
         mtx_ff    <= mtx_in;
         mty_ff    <= mty_in;
         cnt_ff    <= cnt_in;
      end
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      geom_ff <= geom_in;
   end

endmodule

// File: rtl/ita_mean.sv
// Three-lane restoring divider for tile means, one quotient bit per cycle.
// The quotient is known to fit CH_W bits. Uses ita_pkg.
module ita_mean (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  ita_pkg::sum3_type              sums,
   input  logic [ita_pkg::AREA_W-1:0]     area,
   output logic                           done,
   output ita_pkg::mean3_type             mean
);

   localparam int SW = ita_pkg::SUM_W;

   ita_pkg::sum3_type  rem_ff, rem_in;
   ita_pkg::mean3_type q_ff, q_in;
   logic [SW-1:0] div_ff, div_in;
   logic [$clog2(ita_pkg::MEAN_STEPS)-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in, done_ff, done_in;

   assign done = done_ff;
   assign mean = q_ff;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = sums;
         div_in = SW'(area) << (ita_pkg::MEAN_STEPS - 1);
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[i] >= div_ff) begin
               rem_in[i] = rem_ff[i] - div_ff;
               q_in[i]   = {q_ff[i][ita_pkg::CH_W-2:0], 1'b1};
            end else begin
               q_in[i]   = {q_ff[i][ita_pkg::CH_W-2:0], 1'b0};
            end
         end
         div_in = div_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

endmodule

// File: rtl/ita_checker.sv
// Port-level checks for the tile averaging block, bound to the top level.
// Depends on ita_pkg and image_tile_average_defines.svh.
`include "image_tile_average_defines.svh"

module ita_checker (
   input logic              clock,
   input logic              reset,
   input logic              csr_we,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ita_pkg::tile_type rsp_data
);

   // a stalled result beat keeps its payload
   `ITA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")
   // a register write blocks pixels while the geometry is recomputed
   `ITA_ASSERT_NEXT(a_csr_blocks, csr_we, !req_ready, "pixel accepted right after csr write")
   // handshake lines are never unknown out of reset
   `ITA_ASSERT_NOW(a_hs_known, 1'b1, !$isunknown({req_valid, req_ready, rsp_valid, rsp_ready}), "unknown handshake")

endmodule

bind image_tile_average ita_checker u_ita_checker (
   .clock     (clock),
   .reset     (reset),
   .csr_we    (csr_we),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);

// File: test/tb_image_tile_average.sv
// Self-checking bench for image_tile_average: pixel frames in, tile means out.
// Depends on ita_pkg, ita_req_if, ita_rsp_if and the image_tile_average RTL.
// A local tile predictor sets the expected tile stream; registers change only between frames.
module tb_image_tile_average;

   localparam int FRAME_DIM_MAX = 4096;
   localparam int TILE_COLS_MAX = 256;
   localparam int RAND_PIXELS   = 1400;

   typedef struct packed {
      ita_pkg::pixel_type px;
      logic               typed;
      ita_pkg::tile_type  res;
   } dir_row_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [ita_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ita_pkg::CSR_DATA_W-1:0] csr_wdata;

   ita_req_if req_bus ();
   ita_rsp_if rsp_bus ();

   image_tile_average i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // Predictor state: register copy, tile column sums, raster position, latched geometry.
   int       reg_val [6];
   longint   col_sum_a [TILE_COLS_MAX];
   longint   col_sum_b [TILE_COLS_MAX];
   longint   col_sum_c [TILE_COLS_MAX];
   int       pos_x, pos_y, span_w, span_h, side_w, side_h;

   ita_pkg::tile_type pending_tiles [$];
   int       err_count;
   int       tiles_seen;
   int       pixels_sent;
   int       rand_pixels;
   int       phase_count;
   bit       quiet;

   // Four frames of 2x2 pixels, one 2x2 tile each.
   dir_row_type dir_rows [16] = '{
      '{'{8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{8'hff, 8'hff, 8'hff}, 1'b1, '{8'hff, 8'hff, 8'hff, 8'd0, 12'd0, 1'b1}},
      '{'{8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{'{8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{'{8'h00, 8'h00, 8'h00}, 1'b0, '0},
      '{'{8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'd0, 12'd0, 1'b1}},
      '{'{8'hff, 8'h00, 8'h80}, 1'b0, '0},
      '{'{8'h00, 8'hff, 8'h80}, 1'b0, '0},
      '{'{8'hff, 8'h00, 8'h80}, 1'b0, '0},
      '{'{8'h00, 8'hff, 8'h80}, 1'b1, '{8'd127, 8'd127, 8'd128, 8'd0, 12'd0, 1'b1}},
      '{'{8'h01, 8'h10, 8'haa}, 1'b0, '0},
      '{'{8'h02, 8'h20, 8'h55}, 1'b0, '0},
      '{'{8'h04, 8'h40, 8'h0f}, 1'b0, '0},
      '{'{8'h08, 8'h80, 8'hf0}, 1'b0, '0}
   };

   function automatic int clamp_dim(int d);
      if (d == 0) return 1;
      if (d > FRAME_DIM_MAX) return FRAME_DIM_MAX;
      return d;
   endfunction

   function automatic int side_len(int dim, int sld, int mt);
      int n;
      n = ((int'(ita_pkg::SLIDER_FULL) - sld) * mt) / int'(ita_pkg::SLIDER_FULL);
      if (n < 1) n = 1;
      return dim / n;
   endfunction

   // Advances the predictor by one pixel; returns 1 when a tile closes.
   function automatic bit tile_predict(input ita_pkg::pixel_type p,
                                       output ita_pkg::tile_type t);
      int     ncols, nrows, kept, col, row, dx, dy;
      longint area;
      bit     hit;
      hit = 1'b0;
      t   = '0;
      if (pos_x == 0 && pos_y == 0) begin
         span_w = clamp_dim(reg_val[ita_pkg::CSR_IMAGE_WIDTH]);
         span_h = clamp_dim(reg_val[ita_pkg::CSR_IMAGE_HEIGHT]);
         side_w = side_len(span_w, reg_val[ita_pkg::CSR_SLIDER_X],
                           reg_val[ita_pkg::CSR_MAX_TILES_X]);
         side_h = side_len(span_h, reg_val[ita_pkg::CSR_SLIDER_Y],
                           reg_val[ita_pkg::CSR_MAX_TILES_Y]);
      end
      if (side_w != 0 && side_h != 0) begin
         ncols = span_w / side_w;
         nrows = span_h / side_h;
         kept  = (ncols < TILE_COLS_MAX) ? ncols : TILE_COLS_MAX;
         col   = pos_x / side_w;
         dx    = pos_x % side_w;
         row   = pos_y / side_h;
         dy    = pos_y % side_h;
         if (col < kept && row < nrows) begin
            if (dx == 0 && dy == 0) begin
               col_sum_a[col] = p.chan_a;
               col_sum_b[col] = p.chan_b;
               col_sum_c[col] = p.chan_c;
            end else begin
               col_sum_a[col] += p.chan_a;
               col_sum_b[col] += p.chan_b;
               col_sum_c[col] += p.chan_c;
            end
            if (dx == side_w - 1 && dy == side_h - 1) begin
               area         = longint'(side_w) * longint'(side_h);
               t.avg_a      = ita_pkg::CH_W'(col_sum_a[col] / area);
               t.avg_b      = ita_pkg::CH_W'(col_sum_b[col] / area);
               t.avg_c      = ita_pkg::CH_W'(col_sum_c[col] / area);
               t.tile_col   = ita_pkg::TCOL_W'(col);
               t.tile_row   = ita_pkg::TROW_W'(row);
               t.frame_done = (col == kept - 1 && row == nrows - 1);
               hit          = 1'b1;
            end
         end
      end
      if (pos_x + 1 >= span_w) begin
         pos_x = 0;
         pos_y = (pos_y + 1 >= span_h) ? 0 : pos_y + 1;
      end else begin
         pos_x = pos_x + 1;
      end
      return hit;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= quiet || ($urandom_range(99) >= 6);
   end

   // Result beat checker.
   always @(posedge clock) begin
      ita_pkg::tile_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.data;
         tiles_seen++;
         if (pending_tiles.size() == 0) begin
            err_count++;
            $display("%0t: tile beat expected none actual %p", $time, got);
         end else begin
            want = pending_tiles.pop_front();
            if (got.avg_a !== want.avg_a || got.avg_b !== want.avg_b ||
                got.avg_c !== want.avg_c) begin
               err_count++;
               $display("%0t: tile means expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                        want.avg_a, want.avg_b, want.avg_c, got.avg_a, got.avg_b, got.avg_c);
            end
            if (got.tile_col !== want.tile_col || got.tile_row !== want.tile_row) begin
               err_count++;
               $display("%0t: tile position expected (%0d,%0d) actual (%0d,%0d)", $time,
                        want.tile_col, want.tile_row, got.tile_col, got.tile_row);
            end
            if (got.frame_done !== want.frame_done) begin
               err_count++;
               $display("%0t: frame_done expected %0b actual %0b", $time,
                        want.frame_done, got.frame_done);
            end
         end
      end
   end

   task automatic send_pixel(input ita_pkg::pixel_type p, input bit typed,
                             input ita_pkg::tile_type res);
      ita_pkg::tile_type t;
      if (!quiet && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pixels_sent++;
      if (tile_predict(p, t)) pending_tiles = {pending_tiles, (typed ? res : t)};
   endtask

   // Drains every tile in flight, then leaves time for a pixel still in the pipe.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_tiles.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_regs(input int w, input int h, input int sx, input int sy,
                           input int mx, input int my);
      int vals [6];
      int masks [6];
      vals  = '{w, h, sx, sy, mx, my};
      masks = '{13'h1fff, 13'h1fff, 7'h7f, 7'h7f, 9'h1ff, 9'h1ff};
      settle();
      phase_count++;
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= ita_pkg::CSR_IDX_W'(i);
         csr_wdata <= ita_pkg::CSR_DATA_W'(vals[i]);
         reg_val[i] = vals[i] & masks[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_frames(input int w, input int h, input int sx, input int sy,
                             input int mx, input int my, input int frames);
      int total;
      set_regs(w, h, sx, sy, mx, my);
      total = frames * clamp_dim(w & 13'h1fff) * clamp_dim(h & 13'h1fff);
      for (int i = 0; i < total; i++) begin
         send_pixel(ita_pkg::pixel_type'(24'($urandom)), 1'b0, '0);
      end
   endtask

   initial begin
      int w, h, frames;
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      quiet       = 1'b0;
      err_count   = 0;
      tiles_seen  = 0;
      pixels_sent = 0;
      rand_pixels = 0;
      phase_count = 0;
      reg_val = '{int'(ita_pkg::RST_IMAGE_WIDTH), int'(ita_pkg::RST_IMAGE_HEIGHT),
                  int'(ita_pkg::RST_SLIDER), int'(ita_pkg::RST_SLIDER),
                  int'(ita_pkg::RST_MAX_TILES_X), int'(ita_pkg::RST_MAX_TILES_Y)};
      pos_x = 0;
      pos_y = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_regs(2, 2, 0, 0, 1, 1);
      foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].res);

      // Zero sizes count as 1, zero max tiles floors the count at 1.
      run_frames(0, 0, 0, 0, 0, 0, 5);
      // Full sliders: count floors at 1, one tile covers the frame.
      run_frames(7, 3, 127, 127, 511, 511, 3);
      // More tiles than pixels: tile side of zero, nothing comes out.
      run_frames(5, 2, 0, 0, 200, 1, 2);
      // Leftover pixels at the right and bottom edges, which fall in no tile.
      run_frames(10, 7, 0, 0, 3, 2, 2);
      quiet = 1'b1;
      // One-pixel tiles, columns past the limit are dropped.
      run_frames(300, 1, 0, 0, 300, 1, 1);
      quiet = 1'b0;

      while (rand_pixels < RAND_PIXELS) begin
         w = $urandom_range(1, 40);
         h = $urandom_range(1, 12);
         frames = (160 / (w * h)) + 1;
         quiet = ($urandom_range(9) == 0);
         run_frames(w, h,
                    ($urandom_range(3) == 0) ? 127 * $urandom_range(1) : $urandom_range(127),
                    ($urandom_range(3) == 0) ? 127 * $urandom_range(1) : $urandom_range(127),
                    ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(0, 10),
                    ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(0, 6),
                    frames);
         rand_pixels += frames * w * h;
      end
      quiet = 1'b0;

      settle();
      $display("Sent %0d pixels over %0d register settings; %0d tiles checked.",
               pixels_sent, phase_count, tiles_seen);
      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/ita_pkg.sv
rtl/ita_req_if.sv
rtl/ita_rsp_if.sv
rtl/ita_geom.sv
rtl/ita_mean.sv
rtl/image_tile_average.sv
rtl/ita_checker.sv
test/tb_image_tile_average.sv
